// File: rtl/nearest_neighbor_upsampler_assert.svh
// Assertion macros shared by the upsampler RTL.
`ifndef NEAREST_NEIGHBOR_UPSAMPLER_ASSERT_SVH
`define NEAREST_NEIGHBOR_UPSAMPLER_ASSERT_SVH

// expr must never be true outside reset
`define NNU_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("nnu assertion failed");

// ante in a cycle implies cons in the same cycle
`define NNU_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nnu assertion failed");

// ante in a cycle implies cons in the next cycle
`define NNU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nnu assertion failed");

`endif

// File: rtl/nnu_pkg.sv
package nnu_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_DATA_WIDTH = 16;

	localparam int SCALE_W    = 4;
	localparam int SCALE_MAX  = 8;
	localparam int IN_WIDTH_W = 11;
	localparam int HEIGHT_W   = 16;
	localparam int REPLAY_W   = 3;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [SCALE_W-1:0]    RST_STRIDE_H  = 4'd2;
	localparam logic [SCALE_W-1:0]    RST_STRIDE_X  = 4'd2;
	localparam logic [IN_WIDTH_W-1:0] RST_IN_WIDTH  = 11'd1024;
	localparam logic [HEIGHT_W-1:0]   RST_IN_HEIGHT = 16'd1;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_STRIDE_H  = 2'd0,
		CFG_STRIDE_X  = 2'd1,
		CFG_IN_WIDTH  = 2'd2,
		CFG_IN_HEIGHT = 2'd3
	} cfg_index_t;

	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_DRAIN = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_REFUSED     = 2'd1,
		ST_IDLE_DRAIN  = 2'd2
	} status_t;

	// one run of output copies, handed from front to back
	typedef struct packed {
		status_t              status;
		logic                 row_end;
		logic                 plane_end;
		logic [SCALE_W-1:0]   run_len;
	} job_t;

	function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
		logic [SCALE_W-1:0] r;
		r = v;
		if (v == '0)
			r = SCALE_W'(1);
		else if (v > SCALE_W'(SCALE_MAX))
			r = SCALE_W'(SCALE_MAX);
		return r;
	endfunction

endpackage

// File: rtl/nnu_ifs.sv
interface nnu_req_if #(parameter int DATA_WIDTH = nnu_pkg::DEF_DATA_WIDTH);
	logic                  valid;
	logic                  ready;
	logic                  req_type;
	logic [DATA_WIDTH-1:0] pixel_in;

	modport source (output valid, req_type, pixel_in, input ready);
	modport sink   (input valid, req_type, pixel_in, output ready);
endinterface

interface nnu_res_if #(parameter int DATA_WIDTH = nnu_pkg::DEF_DATA_WIDTH);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] pixel_out;
	logic                  last_in_run;
	logic                  row_end;
	logic                  plane_end;
	logic [1:0]            status;

	modport source (output valid, pixel_out, last_in_run, row_end, plane_end, status,
		input ready);
	modport sink   (input valid, pixel_out, last_in_run, row_end, plane_end, status,
		output ready);
endinterface

interface nnu_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [nnu_pkg::CFG_INDEX_W-1:0]    index;
	logic [nnu_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/nnu_front.sv
module nnu_front #(
	parameter int MAX_WIDTH  = nnu_pkg::DEF_MAX_WIDTH,
	parameter int DATA_WIDTH = nnu_pkg::DEF_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	nnu_cfg_if.sink               cfg,
	nnu_req_if.sink               req,
	output nnu_pkg::job_t         job,
	output logic [DATA_WIDTH-1:0] job_pixel,
	output logic                  job_valid,
	input  logic                  job_ready
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW = ($clog2(MAX_WIDTH + 1) > nnu_pkg::IN_WIDTH_W) ?
		$clog2(MAX_WIDTH + 1) : nnu_pkg::IN_WIDTH_W;
	localparam int HW = nnu_pkg::HEIGHT_W;
	localparam int SW = nnu_pkg::SCALE_W;
	localparam int RW = nnu_pkg::REPLAY_W;

	logic [SW-1:0]                  stride_h_q, stride_x_q;
	logic [nnu_pkg::IN_WIDTH_W-1:0] in_width_q;
	logic [HW-1:0]                  in_height_q;

	logic [AW-1:0] column_count_q, replay_column_q;
	logic [HW-1:0] row_count_q;
	logic          replay_active_q;
	logic [RW-1:0] replay_row_q;

	logic [DATA_WIDTH-1:0] line_mem [MAX_WIDTH];
	logic [DATA_WIDTH-1:0] rd_q;

	logic                  valid_s1;
	nnu_pkg::job_t         job_s1;
	logic [DATA_WIDTH-1:0] pix_s1;
	logic                  use_mem_s1;

	logic [EW-1:0]         w_eff;
	logic [HW-1:0]         h_eff;
	logic [SW-1:0]         sh_eff, sw_eff;
	logic [AW-1:0]         col_wr, col_rd;
	logic                  wr_row_end, rd_row_end, last_row, final_rep;
	logic                  is_drain, accept;
	nnu_pkg::job_t         job_d;
	logic [DATA_WIDTH-1:0] pix_d;
	logic                  use_mem_d;

	assign cfg.ready = 1'b1;
	assign req.ready = !valid_s1 || job_ready;
	assign accept    = req.valid && req.ready;
	assign is_drain  = (req.req_type == nnu_pkg::REQ_DRAIN);

	always_comb begin
		if (in_width_q == '0)
			w_eff = EW'(1);
		else if (EW'(in_width_q) > EW'(MAX_WIDTH))
			w_eff = EW'(MAX_WIDTH);
		else
			w_eff = EW'(in_width_q);
		h_eff  = (in_height_q == '0) ? HW'(1) : in_height_q;
		sh_eff = nnu_pkg::clamp_scale(stride_h_q);
		sw_eff = nnu_pkg::clamp_scale(stride_x_q);

		// counters left beyond a shrunk width snap to the last column
		col_wr = (EW'(column_count_q) >= w_eff) ? AW'(w_eff - EW'(1)) : column_count_q;
		col_rd = (EW'(replay_column_q) >= w_eff) ? AW'(w_eff - EW'(1)) : replay_column_q;
		wr_row_end = (EW'(col_wr) + EW'(1)) >= w_eff;
		rd_row_end = (EW'(col_rd) + EW'(1)) >= w_eff;
		last_row   = ({1'b0, row_count_q} + (HW+1)'(1)) >= {1'b0, h_eff};
		final_rep  = ({1'b0, replay_row_q} + (RW+1)'(2)) >= (RW+1)'(sh_eff);

		job_d.status    = nnu_pkg::ST_OK;
		job_d.row_end   = 1'b0;
		job_d.plane_end = 1'b0;
		job_d.run_len   = sw_eff;
		pix_d           = req.pixel_in;
		use_mem_d       = 1'b0;
		if (is_drain) begin
			pix_d = '0;
			if (!replay_active_q) begin
				job_d.status  = nnu_pkg::ST_IDLE_DRAIN;
				job_d.run_len = SW'(1);
			end else begin
				job_d.row_end   = rd_row_end;
				job_d.plane_end = rd_row_end && final_rep && last_row;
				use_mem_d       = 1'b1;
			end
		end else begin
			if (replay_active_q) begin
				job_d.status  = nnu_pkg::ST_REFUSED;
				job_d.run_len = SW'(1);
				pix_d         = '0;
			end else begin
				job_d.row_end   = wr_row_end;
				job_d.plane_end = wr_row_end && (sh_eff == SW'(1)) && last_row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_h_q      <= nnu_pkg::RST_STRIDE_H;
			stride_x_q      <= nnu_pkg::RST_STRIDE_X;
			in_width_q      <= nnu_pkg::RST_IN_WIDTH;
			in_height_q     <= nnu_pkg::RST_IN_HEIGHT;
			column_count_q  <= '0;
			row_count_q     <= '0;
			replay_active_q <= 1'b0;
			replay_row_q    <= '0;
			replay_column_q <= '0;
			valid_s1        <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (nnu_pkg::cfg_index_t'(cfg.index))
					nnu_pkg::CFG_STRIDE_H:  stride_h_q  <= cfg.data[SW-1:0];
					nnu_pkg::CFG_STRIDE_X:  stride_x_q  <= cfg.data[SW-1:0];
					nnu_pkg::CFG_IN_WIDTH:  in_width_q  <= cfg.data[nnu_pkg::IN_WIDTH_W-1:0];
					nnu_pkg::CFG_IN_HEIGHT: in_height_q <= cfg.data[HW-1:0];
				endcase
			end

			if (accept)
				valid_s1 <= 1'b1;
			else if (job_ready)
				valid_s1 <= 1'b0;

			if (accept && !is_drain && !replay_active_q) begin
				if (wr_row_end) begin
					column_count_q <= '0;
					if (sh_eff > SW'(1)) begin
						replay_active_q <= 1'b1;
						replay_row_q    <= '0;
						replay_column_q <= '0;
					end else begin
						row_count_q <= last_row ? '0 : row_count_q + HW'(1);
					end
				end else begin
					column_count_q <= col_wr + AW'(1);
				end
			end

			if (accept && is_drain && replay_active_q) begin
				if (rd_row_end) begin
					replay_column_q <= '0;
					if (final_rep) begin
						replay_active_q <= 1'b0;
						replay_row_q    <= '0;
						row_count_q     <= last_row ? '0 : row_count_q + HW'(1);
					end else begin
						replay_row_q <= replay_row_q + RW'(1);
					end
				end else begin
					replay_column_q <= col_rd + AW'(1);
				end
			end
		end
	end

	// line store; read data stays put while the stage is stalled
	always_ff @(posedge clk) begin
		if (accept && !is_drain && !replay_active_q)
			line_mem[col_wr] <= req.pixel_in;
		if (accept && is_drain && replay_active_q)
			rd_q <= line_mem[col_rd];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1     <= job_d;
			pix_s1     <= pix_d;
			use_mem_s1 <= use_mem_d;
		end
	end

	assign job       = job_s1;
	assign job_pixel = use_mem_s1 ? rd_q : pix_s1;
	assign job_valid = valid_s1;

endmodule

// File: rtl/nnu_queue.sv
`include "nearest_neighbor_upsampler_assert.svh"

module nnu_queue #(
	parameter int DATA_WIDTH = nnu_pkg::DEF_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nnu_pkg::job_t         push_job,
	input  logic [DATA_WIDTH-1:0] push_pixel,
	input  logic                  push_valid,
	output logic                  push_ready,
	output nnu_pkg::job_t         head_job,
	output logic [DATA_WIDTH-1:0] head_pixel,
	output logic                  head_valid,
	input  logic                  pop
);

	localparam int DEPTH = nnu_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	nnu_pkg::job_t         job_q [DEPTH];
	logic [DATA_WIDTH-1:0] pix_q [DEPTH];
	logic [PW-1:0]         wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]         count_q;
	logic                  push;

	assign push_ready = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign head_job   = job_q[rd_ptr_q];
	assign head_pixel = pix_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			job_q[wr_ptr_q] <= push_job;
			pix_q[wr_ptr_q] <= push_pixel;
		end
	end

	`NNU_ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CW'(DEPTH))
	`NNU_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && !head_valid)
	`NNU_ASSERT_NEXT(a_count_grows, clk, arst_n, push && !pop,
		count_q == $past(count_q) + CW'(1))
	`NNU_ASSERT_NEXT(a_count_shrinks, clk, arst_n, pop && !push,
		count_q == $past(count_q) - CW'(1))

endmodule

// File: rtl/nnu_back.sv
`include "nearest_neighbor_upsampler_assert.svh"

module nnu_back #(
	parameter int DATA_WIDTH = nnu_pkg::DEF_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  nnu_pkg::job_t         head_job,
	input  logic [DATA_WIDTH-1:0] head_pixel,
	input  logic                  head_valid,
	output logic                  pop,
	nnu_res_if.source             res
);

	localparam int SW = nnu_pkg::SCALE_W;

	logic [SW-2:0]         copy_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] pixel_q;
	logic                  last_q, row_end_q, plane_end_q;
	nnu_pkg::status_t      status_q;
	logic                  load, last_copy;

	assign load      = head_valid && (!out_valid_q || res.ready);
	assign last_copy = (SW'(copy_q) + SW'(1)) >= head_job.run_len;
	assign pop       = load && last_copy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
			if (load)
				copy_q <= last_copy ? '0 : copy_q + (SW-1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_q     <= head_pixel;
			last_q      <= last_copy;
			row_end_q   <= last_copy && head_job.row_end;
			plane_end_q <= last_copy && head_job.plane_end;
			status_q    <= head_job.status;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.pixel_out   = pixel_q;
	assign res.last_in_run = last_q;
	assign res.row_end     = row_end_q;
	assign res.plane_end   = plane_end_q;
	assign res.status      = status_q;

	`NNU_ASSERT_IMPLIES(a_copy_in_run, clk, arst_n, head_valid,
		SW'(copy_q) < head_job.run_len)
	`NNU_ASSERT_IMPLIES(a_error_single, clk, arst_n,
		out_valid_q && (status_q != nnu_pkg::ST_OK), last_q && !row_end_q && !plane_end_q)
	`NNU_ASSERT_IMPLIES(a_plane_on_row, clk, arst_n, out_valid_q && plane_end_q,
		row_end_q && last_q)

endmodule

// File: rtl/nearest_neighbor_upsampler.sv
// Path: a request's first copy passes the front stage, the job queue and the output register
//   before it is valid on the result port.
// Throughput: one result per cycle while the result port is ready and a job is queued; an ok
//   request gives the clamped horizontal scale (1..8) copies, a status-only result one copy.
// Reset (arst_n low, asynchronous): registers to defaults, counters and replay cleared,
//   queue and output emptied; the line store is not cleared.
module nearest_neighbor_upsampler #(
	parameter int MAX_WIDTH  = nnu_pkg::DEF_MAX_WIDTH,
	parameter int DATA_WIDTH = nnu_pkg::DEF_DATA_WIDTH
) (
	input logic       clk,
	input logic       arst_n,
	nnu_cfg_if.sink   cfg,
	nnu_req_if.sink   req,
	nnu_res_if.source res
);

	nnu_pkg::job_t         fe_job, head_job;
	logic [DATA_WIDTH-1:0] fe_pixel, head_pixel;
	logic                  fe_valid, fe_ready, head_valid, pop;

	nnu_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.job       (fe_job),
		.job_pixel (fe_pixel),
		.job_valid (fe_valid),
		.job_ready (fe_ready)
	);

	nnu_queue #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (fe_job),
		.push_pixel (fe_pixel),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.head_job   (head_job),
		.head_pixel (head_pixel),
		.head_valid (head_valid),
		.pop        (pop)
	);

	nnu_back #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_job   (head_job),
		.head_pixel (head_pixel),
		.head_valid (head_valid),
		.pop        (pop),
		.res        (res)
	);

endmodule
